// File: hw/rtl/ddrf_pkg.sv
// Shared types, codes and constants of the differential drive ramp filter.
package ddrf_pkg;

  localparam int FRAC_BITS = 8;
  localparam int RAMP_W    = 9;
  localparam int SMOOTH_W  = FRAC_BITS + 10;
  localparam int ACC_W     = SMOOTH_W + 11;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [3:0] {
    CMD_TICK        = 4'd0,
    CMD_STOP        = 4'd1,
    CMD_BRAKE       = 4'd2,
    CMD_FORWARD     = 4'd3,
    CMD_BACKWARD    = 4'd4,
    CMD_SPIN_RIGHT  = 4'd5,
    CMD_SPIN_LEFT   = 4'd6,
    CMD_PIVOT_RIGHT = 4'd7,
    CMD_PIVOT_LEFT  = 4'd8,
    CMD_PIVOT_RBACK = 4'd9,
    CMD_PIVOT_LBACK = 4'd10,
    CMD_SET         = 4'd11
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_SPEED  = 2'd0,
    REG_ACCEL_LIMIT = 2'd1,
    REG_ALPHA       = 2'd2
  } reg_idx_t;

  localparam logic [1:0] DIR_COAST = 2'd0;
  localparam logic [1:0] DIR_REV   = 2'd1;
  localparam logic [1:0] DIR_FWD   = 2'd2;
  localparam logic [1:0] DIR_BRAKE = 2'd3;

  localparam logic [7:0] BASE_RESET  = 8'd200;
  localparam logic [7:0] ACCEL_RESET = 8'd10;
  localparam logic [8:0] ALPHA_RESET = 9'd51;
  localparam logic [7:0] DUTY_MAX    = 8'd255;
  localparam logic [8:0] ALPHA_ONE   = 9'd256;

  typedef struct packed {
    logic [7:0] base_speed;
    logic [7:0] accel_limit;
    logic [8:0] alpha;
  } ddrf_cfg_t;

  typedef struct packed {
    logic                     load;
    logic signed [RAMP_W-1:0] left;
    logic signed [RAMP_W-1:0] right;
  } ddrf_tgt_t;

  typedef struct packed {
    logic signed [RAMP_W-1:0]   ramp;
    logic signed [SMOOTH_W-1:0] smooth;
    logic [1:0]                 dir;
    logic [7:0]                 duty;
  } ddrf_wheel_t;

endpackage

// File: hw/rtl/ddrf_target.sv
// Target decoder: wheel targets from the move, turn and set commands.
module ddrf_target
  import ddrf_pkg::*;
(
  input  cmd_t                     cmd,
  input  logic signed [8:0]        correction,
  input  logic signed [8:0]        new_left,
  input  logic signed [8:0]        new_right,
  input  logic [7:0]               base_speed,
  output ddrf_tgt_t                tgt
);

  logic signed [10:0]       sum_l;
  logic signed [10:0]       sum_r;
  logic [7:0]               clip_l;
  logic [7:0]               clip_r;
  logic signed [RAMP_W-1:0] pos_l;
  logic signed [RAMP_W-1:0] pos_r;
  logic signed [RAMP_W-1:0] base_p;
  logic signed [RAMP_W-1:0] base_n;
  logic signed [RAMP_W-1:0] set_l;
  logic signed [RAMP_W-1:0] set_r;

  localparam logic signed [RAMP_W-1:0] SET_MIN = -9'sd256;

  always_comb begin
    sum_l  = $signed({3'b000, base_speed}) - 11'(correction);
    sum_r  = $signed({3'b000, base_speed}) + 11'(correction);
    clip_l = sum_l < 0 ? 8'd0 : (sum_l > 11'sd255 ? DUTY_MAX : sum_l[7:0]);
    clip_r = sum_r < 0 ? 8'd0 : (sum_r > 11'sd255 ? DUTY_MAX : sum_r[7:0]);
    pos_l  = $signed({1'b0, clip_l});
    pos_r  = $signed({1'b0, clip_r});
    base_p = $signed({1'b0, base_speed});
    base_n = RAMP_W'(-base_p);
    set_l  = new_left == SET_MIN ? -9'sd255 : new_left;
    set_r  = new_right == SET_MIN ? -9'sd255 : new_right;

    tgt.load  = 1'b1;
    tgt.left  = '0;
    tgt.right = '0;
    unique case (cmd)
      CMD_FORWARD: begin
        tgt.left  = pos_l;
        tgt.right = pos_r;
      end
      CMD_BACKWARD: begin
        tgt.left  = RAMP_W'(-pos_l);
        tgt.right = RAMP_W'(-pos_r);
      end
      CMD_SPIN_RIGHT: begin
        tgt.left  = base_p;
        tgt.right = base_n;
      end
      CMD_SPIN_LEFT: begin
        tgt.left  = base_n;
        tgt.right = base_p;
      end
      CMD_PIVOT_RIGHT: tgt.left  = base_p;
      CMD_PIVOT_LEFT:  tgt.right = base_p;
      CMD_PIVOT_RBACK: tgt.left  = base_n;
      CMD_PIVOT_LBACK: tgt.right = base_n;
      CMD_SET: begin
        tgt.left  = set_l;
        tgt.right = set_r;
      end
      default: tgt.load = 1'b0;
    endcase
  end

endmodule

// File: hw/rtl/ddrf_wheel.sv
// One wheel's tick update: slew-limited ramp, low-pass filter and drive decode.
module ddrf_wheel
  import ddrf_pkg::*;
(
  input  logic signed [RAMP_W-1:0]   target,
  input  logic signed [RAMP_W-1:0]   ramp,
  input  logic signed [SMOOTH_W-1:0] smooth,
  input  ddrf_cfg_t                  cfg,
  output ddrf_wheel_t                upd
);

  localparam logic signed [ACC_W-1:0]    ACC_RND = ACC_W'(255);
  localparam logic signed [SMOOTH_W-1:0] V_RND   = SMOOTH_W'((1 << FRAC_BITS) - 1);

  logic signed [9:0]            diff;
  logic signed [9:0]            lim;
  logic signed [9:0]            step;
  logic signed [9:0]            ramp_sum;
  logic signed [RAMP_W-1:0]     ramp_n;
  logic [8:0]                   a_eff;
  logic [8:0]                   a_inv;
  logic signed [SMOOTH_W+9:0]   prod_s;
  logic signed [RAMP_W+9:0]     prod_r;
  logic signed [ACC_W-1:0]      acc;
  logic signed [ACC_W-1:0]      acc_adj;
  logic signed [ACC_W-1:0]      acc_div;
  logic signed [SMOOTH_W-1:0]   smooth_n;
  logic signed [SMOOTH_W-1:0]   s_adj;
  logic signed [SMOOTH_W-1:0]   v;
  logic signed [SMOOTH_W-1:0]   mag;

  always_comb begin
    diff     = 10'(target) - 10'(ramp);
    lim      = $signed({2'b00, cfg.accel_limit});
    step     = diff > lim ? lim : (diff < -lim ? 10'(-lim) : diff);
    ramp_sum = 10'(ramp) + step;
    ramp_n   = (diff > 10'sd1 || diff < -10'sd1) ? ramp_sum[RAMP_W-1:0] : target;

    a_eff    = cfg.alpha > ALPHA_ONE ? ALPHA_ONE : cfg.alpha;
    a_inv    = ALPHA_ONE - a_eff;
    prod_s   = smooth * $signed({1'b0, a_inv});
    prod_r   = ramp_n * $signed({1'b0, a_eff});
    acc      = ACC_W'(prod_s) + (ACC_W'(prod_r) <<< FRAC_BITS);
    acc_adj  = acc + (acc[ACC_W-1] ? ACC_RND : '0);
    acc_div  = acc_adj >>> 8;
    smooth_n = acc_div[SMOOTH_W-1:0];

    s_adj    = smooth_n + (smooth_n[SMOOTH_W-1] ? V_RND : '0);
    v        = s_adj >>> FRAC_BITS;
    mag      = v[SMOOTH_W-1] ? SMOOTH_W'(-v) : v;

    upd.ramp   = ramp_n;
    upd.smooth = smooth_n;
    upd.dir    = v[SMOOTH_W-1] ? DIR_REV : DIR_FWD;
    upd.duty   = mag > SMOOTH_W'(255) ? DUTY_MAX : mag[7:0];
  end

endmodule

// File: hw/rtl/differential_drive_ramp_filter_core.sv
// Top level of the differential drive ramp filter: beat registers, state and control.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command beat with its
//   correction and set-target fields. Result channel (out_valid/out_ready)
//   returns one beat per command: the drive direction pair and PWM duty of
//   each wheel after that command took effect.
//   Configuration writes (cfg_we, cfg_index, cfg_wdata) load base speed,
//   acceleration limit and filter coefficient; issue them while idle.
//   Path: an accepted beat passes the input register, then the state and
//   result register. Throughput: 1 beat per cycle unless stalled; the whole
//   ramp, filter multiply and drive decode run in one pass per beat.
//   Reset: all targets, ramps and filters clear, wheels coast at zero duty,
//   registers return to base 200, accel 10, alpha 51.
//   Receiver stall: the pending result holds; one more beat waits in the
//   input register, then in_ready drops until the result is taken.
module differential_drive_ramp_filter_core
  import ddrf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [3:0]           in_command,
  input  logic signed [8:0]    in_correction,
  input  logic signed [8:0]    in_new_left,
  input  logic signed [8:0]    in_new_right,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_left_dir,
  output logic [7:0]           out_left_pwm,
  output logic [1:0]           out_right_dir,
  output logic [7:0]           out_right_pwm,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  ddrf_cfg_t                  cfg_r;
  logic                       in_valid_r;
  logic [3:0]                 cmd_r;
  logic signed [8:0]          corr_r;
  logic signed [8:0]          new_l_r;
  logic signed [8:0]          new_r_r;
  logic                       out_valid_r;
  logic                       advance;
  cmd_t                       cmd;
  ddrf_tgt_t                  tgt;
  ddrf_wheel_t                upd_l;
  ddrf_wheel_t                upd_r;

  logic signed [RAMP_W-1:0]   tgt_l_r, tgt_l_nxt;
  logic signed [RAMP_W-1:0]   tgt_r_r, tgt_r_nxt;
  logic signed [RAMP_W-1:0]   ramp_l_r, ramp_l_nxt;
  logic signed [RAMP_W-1:0]   ramp_r_r, ramp_r_nxt;
  logic signed [SMOOTH_W-1:0] smooth_l_r, smooth_l_nxt;
  logic signed [SMOOTH_W-1:0] smooth_r_r, smooth_r_nxt;
  logic [3:0]                 drive_r, drive_nxt;
  logic [7:0]                 duty_l_r, duty_l_nxt;
  logic [7:0]                 duty_r_r, duty_r_nxt;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign cmd      = cmd_t'(cmd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_speed  <= BASE_RESET;
      cfg_r.accel_limit <= ACCEL_RESET;
      cfg_r.alpha       <= ALPHA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_SPEED:  cfg_r.base_speed  <= cfg_wdata[7:0];
        REG_ACCEL_LIMIT: cfg_r.accel_limit <= cfg_wdata[7:0];
        REG_ALPHA:       cfg_r.alpha       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r   <= in_command;
      corr_r  <= in_correction;
      new_l_r <= in_new_left;
      new_r_r <= in_new_right;
    end
  end

  ddrf_target u_target (
    .cmd        (cmd),
    .correction (corr_r),
    .new_left   (new_l_r),
    .new_right  (new_r_r),
    .base_speed (cfg_r.base_speed),
    .tgt        (tgt)
  );

  ddrf_wheel u_wheel_l (
    .target (tgt_l_r),
    .ramp   (ramp_l_r),
    .smooth (smooth_l_r),
    .cfg    (cfg_r),
    .upd    (upd_l)
  );

  ddrf_wheel u_wheel_r (
    .target (tgt_r_r),
    .ramp   (ramp_r_r),
    .smooth (smooth_r_r),
    .cfg    (cfg_r),
    .upd    (upd_r)
  );

  always_comb begin
    tgt_l_nxt    = tgt_l_r;
    tgt_r_nxt    = tgt_r_r;
    ramp_l_nxt   = ramp_l_r;
    ramp_r_nxt   = ramp_r_r;
    smooth_l_nxt = smooth_l_r;
    smooth_r_nxt = smooth_r_r;
    drive_nxt    = drive_r;
    duty_l_nxt   = duty_l_r;
    duty_r_nxt   = duty_r_r;
    unique case (cmd) inside
      CMD_TICK: begin
        ramp_l_nxt   = upd_l.ramp;
        ramp_r_nxt   = upd_r.ramp;
        smooth_l_nxt = upd_l.smooth;
        smooth_r_nxt = upd_r.smooth;
        drive_nxt    = {upd_l.dir, upd_r.dir};
        duty_l_nxt   = upd_l.duty;
        duty_r_nxt   = upd_r.duty;
      end
      CMD_STOP, CMD_BRAKE: begin
        tgt_l_nxt    = '0;
        tgt_r_nxt    = '0;
        ramp_l_nxt   = '0;
        ramp_r_nxt   = '0;
        smooth_l_nxt = '0;
        smooth_r_nxt = '0;
        drive_nxt    = cmd == CMD_BRAKE ? {DIR_BRAKE, DIR_BRAKE} : {DIR_COAST, DIR_COAST};
        duty_l_nxt   = cmd == CMD_BRAKE ? DUTY_MAX : 8'd0;
        duty_r_nxt   = cmd == CMD_BRAKE ? DUTY_MAX : 8'd0;
      end
      default: begin
        if (tgt.load) begin
          tgt_l_nxt = tgt.left;
          tgt_r_nxt = tgt.right;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_l_r     <= '0;
      tgt_r_r     <= '0;
      ramp_l_r    <= '0;
      ramp_r_r    <= '0;
      smooth_l_r  <= '0;
      smooth_r_r  <= '0;
      drive_r     <= '0;
      duty_l_r    <= '0;
      duty_r_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        tgt_l_r    <= tgt_l_nxt;
        tgt_r_r    <= tgt_r_nxt;
        ramp_l_r   <= ramp_l_nxt;
        ramp_r_r   <= ramp_r_nxt;
        smooth_l_r <= smooth_l_nxt;
        smooth_r_r <= smooth_r_nxt;
        drive_r    <= drive_nxt;
        duty_l_r   <= duty_l_nxt;
        duty_r_r   <= duty_r_nxt;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_dir  = drive_r[3:2];
  assign out_left_pwm  = duty_l_r;
  assign out_right_dir = drive_r[1:0];
  assign out_right_pwm = duty_r_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !advance)
    else $error("pending result beat overwritten");

  a_stop_coasts: assert property (@(posedge clk) disable iff (!rst_n)
    advance && cmd == CMD_STOP |=> drive_r == 4'd0 && duty_l_r == 8'd0
      && duty_r_r == 8'd0 && ramp_l_r == '0 && smooth_r_r == '0)
    else $error("stop did not clear drive");

  a_brake_full: assert property (@(posedge clk) disable iff (!rst_n)
    advance && cmd == CMD_BRAKE |=> drive_r == {DIR_BRAKE, DIR_BRAKE}
      && duty_l_r == DUTY_MAX && duty_r_r == DUTY_MAX)
    else $error("brake did not force full drive");

  a_tick_dir: assert property (@(posedge clk) disable iff (!rst_n)
    advance && cmd == CMD_TICK |=> (drive_r[3:2] == DIR_FWD || drive_r[3:2] == DIR_REV)
      && (drive_r[1:0] == DIR_FWD || drive_r[1:0] == DIR_REV))
    else $error("tick left a wheel coasting or braked");

  a_target_holds_drive: assert property (@(posedge clk) disable iff (!rst_n)
    advance && cmd != CMD_TICK && cmd != CMD_STOP && cmd != CMD_BRAKE
      |=> $stable(drive_r) && $stable(duty_l_r) && $stable(duty_r_r))
    else $error("target command changed the drive outputs");

endmodule

// File: tb/tb_differential_drive_ramp_filter_core.sv
// Testbench for the differential drive ramp filter core: scoreboard, stimulus and checks.
module tb_differential_drive_ramp_filter_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ddrf_pkg::*;

  localparam int SPEED_MAX       = 255;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 131;
  localparam int HOLD_CYCLES     = 60;
  localparam int SETTLE_CYCLES   = 4;
  localparam int DRAIN_LIMIT     = 5000;
  localparam int REPORT_LIMIT    = 100;
  localparam int PRESSURE_PHASE  = 4;
  localparam int TIMEOUT_NS      = 1_000_000;

  localparam logic [3:0] CMD_UNUSED_LO = 4'd12;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;
  localparam logic signed [8:0] FIELD_MIN = 9'sh100;
  localparam logic signed [8:0] FIELD_MAX = 9'sh0ff;

  typedef struct packed {
    logic [1:0] left_dir;
    logic [7:0] left_pwm;
    logic [1:0] right_dir;
    logic [7:0] right_pwm;
  } drive_t;

  class drive_scoreboard;
    logic [7:0] base_speed;
    logic [7:0] accel_limit;
    logic [8:0] alpha;
    logic signed [RAMP_W-1:0] tgt_l, tgt_r, ramp_l, ramp_r;
    logic signed [SMOOTH_W-1:0] smooth_l, smooth_r;
    drive_t cur;
    drive_t expected_q[$];
    int failures, items, ticks, halts, reports;

    function new();
      base_speed  = BASE_RESET;
      accel_limit = ACCEL_RESET;
      alpha       = ALPHA_RESET;
      clear_motion();
      cur = '{DIR_COAST, 8'd0, DIR_COAST, 8'd0};
      failures = 0;
      items = 0;
      ticks = 0;
      halts = 0;
      reports = 0;
    endfunction

    function void clear_motion();
      tgt_l = '0;
      tgt_r = '0;
      ramp_l = '0;
      ramp_r = '0;
      smooth_l = '0;
      smooth_r = '0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_BASE_SPEED: base_speed = val[7:0];
        REG_ACCEL_LIMIT: accel_limit = val[7:0];
        REG_ALPHA: alpha = val;
        default: ;
      endcase
    endfunction

    function int clamp(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function logic signed [RAMP_W-1:0] ramp_toward(logic signed [RAMP_W-1:0] r,
                                                   logic signed [RAMP_W-1:0] t);
      int d;
      d = int'(t) - int'(r);
      if (d > 1 || d < -1) begin
        return RAMP_W'(int'(r) + clamp(d, -int'(accel_limit), int'(accel_limit)));
      end
      return t;
    endfunction

    function logic signed [SMOOTH_W-1:0] lowpass(logic signed [SMOOTH_W-1:0] s,
                                                 logic signed [RAMP_W-1:0] r);
      longint a, acc;
      a = (alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha);
      acc = longint'(s) * (longint'(ALPHA_ONE) - a)
            + longint'(r) * (longint'(1) << FRAC_BITS) * a;
      return SMOOTH_W'(acc / longint'(ALPHA_ONE));
    endfunction

    function void wheel_drive(logic signed [SMOOTH_W-1:0] s, output logic [1:0] dir,
                              output logic [7:0] duty);
      longint v, m;
      v = longint'(s) / (longint'(1) << FRAC_BITS);
      m = (v < 0) ? -v : v;
      dir = (v >= 0) ? DIR_FWD : DIR_REV;
      duty = (m > SPEED_MAX) ? DUTY_MAX : 8'(m);
    endfunction

    function void apply_command(logic [3:0] cmd, logic signed [8:0] corr,
                                logic signed [8:0] nl, logic signed [8:0] nr);
      int b, c;
      logic [1:0] dl, dr;
      logic [7:0] pl, pr;
      b = int'(base_speed);
      c = int'(corr);
      items++;
      case (cmd)
        CMD_TICK: begin
          ticks++;
          ramp_l = ramp_toward(ramp_l, tgt_l);
          ramp_r = ramp_toward(ramp_r, tgt_r);
          smooth_l = lowpass(smooth_l, ramp_l);
          smooth_r = lowpass(smooth_r, ramp_r);
          wheel_drive(smooth_l, dl, pl);
          wheel_drive(smooth_r, dr, pr);
          cur = '{dl, pl, dr, pr};
        end
        CMD_STOP: begin
          halts++;
          clear_motion();
          cur = '{DIR_COAST, 8'd0, DIR_COAST, 8'd0};
        end
        CMD_BRAKE: begin
          halts++;
          clear_motion();
          cur = '{DIR_BRAKE, DUTY_MAX, DIR_BRAKE, DUTY_MAX};
        end
        CMD_FORWARD: begin
          tgt_l = RAMP_W'(clamp(b - c, 0, SPEED_MAX));
          tgt_r = RAMP_W'(clamp(b + c, 0, SPEED_MAX));
        end
        CMD_BACKWARD: begin
          tgt_l = RAMP_W'(-clamp(b - c, 0, SPEED_MAX));
          tgt_r = RAMP_W'(-clamp(b + c, 0, SPEED_MAX));
        end
        CMD_SPIN_RIGHT: begin
          tgt_l = RAMP_W'(b);
          tgt_r = RAMP_W'(-b);
        end
        CMD_SPIN_LEFT: begin
          tgt_l = RAMP_W'(-b);
          tgt_r = RAMP_W'(b);
        end
        CMD_PIVOT_RIGHT: begin
          tgt_l = RAMP_W'(b);
          tgt_r = '0;
        end
        CMD_PIVOT_LEFT: begin
          tgt_l = '0;
          tgt_r = RAMP_W'(b);
        end
        CMD_PIVOT_RBACK: begin
          tgt_l = RAMP_W'(-b);
          tgt_r = '0;
        end
        CMD_PIVOT_LBACK: begin
          tgt_l = '0;
          tgt_r = RAMP_W'(-b);
        end
        CMD_SET: begin
          tgt_l = RAMP_W'(clamp(int'(nl), -SPEED_MAX, SPEED_MAX));
          tgt_r = RAMP_W'(clamp(int'(nr), -SPEED_MAX, SPEED_MAX));
        end
        default: ;
      endcase
      expected_q.push_back(cur);
    endfunction

    function void check_result(drive_t got);
      drive_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (reports++ < REPORT_LIMIT) begin
          $display("%0t: unexpected drive beat L %0d/%0d R %0d/%0d", $time,
                   got.left_dir, got.left_pwm, got.right_dir, got.right_pwm);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got.left_dir !== want.left_dir || got.left_pwm !== want.left_pwm ||
          got.right_dir !== want.right_dir || got.right_pwm !== want.right_pwm) begin
        failures++;
        if (reports++ < REPORT_LIMIT) begin
          $display("%0t: drive beat expected L %0d/%0d R %0d/%0d, actual L %0d/%0d R %0d/%0d",
                   $time, want.left_dir, want.left_pwm, want.right_dir, want.right_pwm,
                   got.left_dir, got.left_pwm, got.right_dir, got.right_pwm);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [3:0]           in_command;
  logic signed [8:0]    in_correction;
  logic signed [8:0]    in_new_left;
  logic signed [8:0]    in_new_right;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           out_left_dir;
  logic [7:0]           out_left_pwm;
  logic [1:0]           out_right_dir;
  logic [7:0]           out_right_pwm;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  drive_scoreboard drive_sb;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_request = 1'b0;

  differential_drive_ramp_filter_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_correction (in_correction),
    .in_new_left   (in_new_left),
    .in_new_right  (in_new_right),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_left_dir  (out_left_dir),
    .out_left_pwm  (out_left_pwm),
    .out_right_dir (out_right_dir),
    .out_right_pwm (out_right_pwm),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("differential_drive_ramp_filter_core: mismatch");
    $finish;
  end

  always @(posedge clk) begin : beat_monitor
    drive_t got;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        drive_sb.apply_command(in_command, in_correction, in_new_left, in_new_right);
      end
      if (out_valid && out_ready) begin
        got = '{out_left_dir, out_left_pwm, out_right_dir, out_right_pwm};
        drive_sb.check_result(got);
      end
    end
  end

  initial begin
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_item(input logic [3:0] cmd, input logic signed [8:0] corr,
                           input logic signed [8:0] nl, input logic signed [8:0] nr);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_correction <= corr;
    in_new_left   <= nl;
    in_new_right  <= nr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic random_item();
    int r;
    logic [3:0] cmd;
    logic signed [8:0] corr;
    r = $urandom_range(99);
    if (r < 55) begin
      cmd = CMD_TICK;
    end else if (r < 89) begin
      cmd = 4'($urandom_range(int'(CMD_SET), int'(CMD_FORWARD)));
    end else if (r < 95) begin
      cmd = $urandom_range(1) ? CMD_STOP : CMD_BRAKE;
    end else begin
      cmd = 4'($urandom_range(int'(CMD_UNUSED_HI), int'(CMD_UNUSED_LO)));
    end
    corr = $urandom_range(1) ? 9'($urandom) : 9'($urandom_range(80) - 40);
    send_item(cmd, corr, 9'($urandom), 9'($urandom));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    for (int w = 0; w < DRAIN_LIMIT && drive_sb.pending() > 0; w++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] base, input logic [7:0] accel,
                            input logic [8:0] alpha);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BASE_SPEED;
    cfg_wdata <= {1'b0, base};
    @(posedge clk);
    drive_sb.set_reg(REG_BASE_SPEED, {1'b0, base});
    cfg_index <= REG_ACCEL_LIMIT;
    cfg_wdata <= {1'b0, accel};
    @(posedge clk);
    drive_sb.set_reg(REG_ACCEL_LIMIT, {1'b0, accel});
    cfg_index <= REG_ALPHA;
    cfg_wdata <= alpha;
    @(posedge clk);
    drive_sb.set_reg(REG_ALPHA, alpha);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int n_settings;
    n_settings = 1;
    drive_sb = new();
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_command    <= CMD_TICK;
    in_correction <= '0;
    in_new_left   <= '0;
    in_new_right  <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_BASE_SPEED;
    cfg_wdata     <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(CMD_TICK, '0, '0, '0);
    send_item(CMD_FORWARD, '0, '0, '0);
    repeat (3) send_item(CMD_TICK, '0, '0, '0);
    send_item(CMD_FORWARD, FIELD_MIN, '0, '0);
    send_item(CMD_TICK, '0, '0, '0);
    send_item(CMD_BACKWARD, FIELD_MAX, '0, '0);
    repeat (2) send_item(CMD_TICK, '0, '0, '0);
    send_item(CMD_SPIN_RIGHT, '0, '0, '0);
    send_item(CMD_TICK, '0, '0, '0);
    send_item(CMD_SPIN_LEFT, '0, '0, '0);
    send_item(CMD_TICK, '0, '0, '0);
    send_item(CMD_PIVOT_RIGHT, '0, '0, '0);
    send_item(CMD_PIVOT_LEFT, '0, '0, '0);
    send_item(CMD_PIVOT_RBACK, '0, '0, '0);
    send_item(CMD_PIVOT_LBACK, '0, '0, '0);
    send_item(CMD_TICK, '0, '0, '0);
    send_item(CMD_SET, '0, FIELD_MIN, FIELD_MAX);
    send_item(CMD_TICK, '0, '0, '0);
    send_item(CMD_BRAKE, '0, '0, '0);
    send_item(CMD_TICK, '0, '0, '0);
    send_item(CMD_STOP, '0, '0, '0);
    send_item(CMD_UNUSED_LO, FIELD_MIN, FIELD_MIN, FIELD_MIN);
    send_item(CMD_UNUSED_HI, FIELD_MAX, FIELD_MAX, FIELD_MAX);
    send_item(CMD_TICK, '0, '0, '0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      case (p)
        0: write_regs(8'd255, 8'd255, ALPHA_ONE);
        1: write_regs(8'd0, 8'd1, 9'd1);
        2: write_regs(8'd200, 8'd0, 9'd0);
        3: write_regs(8'd128, 8'd3, 9'd511);
        default: write_regs(8'($urandom_range(255)), 8'($urandom_range(255, 1)),
                            9'($urandom_range(256, 1)));
      endcase
      n_settings++;
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 83; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 83; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      if (p == PRESSURE_PHASE) hold_request = 1'b1;
      repeat (ITEMS_PER_PHASE) random_item();
    end

    drain_results();
    if (drive_sb.pending() > 0) begin
      drive_sb.failures++;
      $display("%0t: %0d expected drive beats never arrived", $time, drive_sb.pending());
    end
    $display("Ran %0d command beats (%0d ticks, %0d stop/brake) over %0d register settings,",
             drive_sb.items, drive_sb.ticks, drive_sb.halts, n_settings);
    $display("with free, sender-gapped, receiver-stalled and mixed handshakes and a hold-off.");
    if (drive_sb.failures == 0) begin
      $display("differential_drive_ramp_filter_core: match");
    end else begin
      $display("differential_drive_ramp_filter_core: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/ddrf_pkg.sv
hw/rtl/ddrf_target.sv
hw/rtl/ddrf_wheel.sv
hw/rtl/differential_drive_ramp_filter_core.sv
tb/tb_differential_drive_ramp_filter_core.sv
